// ===== hdl/fgba_pkg.sv =====
package fgba_pkg;

    localparam int MAX_GROUPS = 16;
    localparam int SLOT_W     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int DATE_W     = 27;
    localparam int KEY_W      = 16;

    localparam logic [DATE_W-1:0] CUTOFF_RESET = 27'd19980902;

    localparam logic [1:0] ST_GROUP   = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    localparam logic [0:0] KIND_ROW    = 1'b0;
    localparam logic [0:0] KIND_FINISH = 1'b1;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic [47:0] qty;
        logic [63:0] price;
        logic [63:0] net_price;
        logic [63:0] charge;
        logic [47:0] disc;
        logic [31:0] cnt;
    } acc_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW_MUL,
        S_ROW_WR,
        S_FIN_SCAN,
        S_FIN_RD,
        S_FIN_DAT,
        S_FIN_DSTART,
        S_FIN_DWAIT,
        S_FIN_OUT
    } state_t;

    typedef enum logic [1:0] {
        DIV_QTY,
        DIV_PRICE,
        DIV_DISC
    } div_sel_t;

endpackage

// ===== hdl/filtered_group_by_aggregation_top.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | kind, ship_date, quantity, extended_price,
//         |           |                    | discount, tax, return_flag, line_status
// out     | output    | out_valid/out_ready| status, group_flag ... row_count, last
// cfg     | input     | cfg_valid/cfg_ready| cfg_data (ship date cutoff)
//
// A kept row does match, product and RAM read, add and write back; other rows only the match.
// A finish, per group, scans every slot for the smallest key, reads its RAM entry, runs three
// divisions (mean quantity, price and discount), then output; an empty finish only outputs.
// The shared one-bit-per-cycle divider sets the finish rate.
// Reset clears valid bits and dropped flag, restores the cutoff; the RAM is not cleared.
// A stalled output holds its item; once a finish is done, new input is taken while it waits.
module filtered_group_by_aggregation_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [26:0] ship_date,
    input  logic [15:0] quantity,
    input  logic [23:0] extended_price,
    input  logic [6:0]  discount,
    input  logic [6:0]  tax,
    input  logic [7:0]  return_flag,
    input  logic [7:0]  line_status,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  group_flag,
    output logic [7:0]  group_status,
    output logic [47:0] sum_qty,
    output logic [63:0] price_total,
    output logic [63:0] net_price_total,
    output logic [63:0] charge_total,
    output logic [22:0] avg_qty,
    output logic [23:0] price_mean,
    output logic [13:0] disc_mean,
    output logic [31:0] row_count,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [26:0] cfg_data
);
    import fgba_pkg::*;

    state_t state_reg, state_next;

    logic [DATE_W-1:0]     cutoff_reg;
    logic [MAX_GROUPS-1:0] used_reg;
    logic [KEY_W-1:0]      keys_reg [MAX_GROUPS];
    logic                  dropped_reg;
    logic                  fin_drop_reg;
    logic                  empty_reg;

    slot_t       slot_reg;
    logic        is_new_reg;
    logic [30:0] dprice_reg;
    logic [38:0] charge_reg;
    logic [15:0] qty_reg;
    logic [6:0]  disc_reg;
    logic [6:0]  tax_reg;
    logic [23:0] extended_price_hold;

    slot_t            scan_idx_reg;
    slot_t            best_slot_reg;
    logic [KEY_W-1:0] best_key_reg;
    logic             have_reg;
    acc_t             acc_reg;
    div_sel_t         div_sel_reg;
    logic [22:0]      avgq_reg;
    logic [23:0]      avgp_reg;
    logic [13:0]      avgd_reg;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [7:0]  gflag_reg;
    logic [7:0]  gstat_reg;
    logic [47:0] sqty_reg;
    logic [63:0] sprice_reg;
    logic [63:0] sdprice_reg;
    logic [63:0] scharge_reg;
    logic [22:0] oavgq_reg;
    logic [23:0] oavgp_reg;
    logic [13:0] oavgd_reg;
    logic [31:0] ocnt_reg;
    logic        last_reg;

    // lookup
    logic [KEY_W-1:0] in_key;
    logic             hit;
    slot_t            hit_slot;
    logic             has_free;
    slot_t            free_slot;
    logic             date_ok;
    logic [6:0]       disc_clip;

    assign in_key    = {return_flag, line_status};
    assign date_ok   = (ship_date <= cutoff_reg);
    assign disc_clip = (discount > 7'd100) ? 7'd100 : discount;

    always_comb
    begin
        hit       = 1'b0;
        hit_slot  = '0;
        has_free  = 1'b0;
        free_slot = '0;
        for (int i = MAX_GROUPS - 1; i >= 0; i--)
        begin
            if (used_reg[i] && (keys_reg[i] == in_key))
            begin
                hit      = 1'b1;
                hit_slot = slot_t'(i);
            end
            if (!used_reg[i])
            begin
                has_free  = 1'b1;
                free_slot = slot_t'(i);
            end
        end
    end

    // control
    logic   in_fire;
    logic   out_free;
    logic   ram_we;
    logic   ram_re;
    slot_t  ram_raddr;
    logic   div_start;
    logic   out_load;
    logic   scan_end;
    acc_t   ram_rdata;
    acc_t   ram_wdata;
    logic   div_busy;
    logic   div_done;
    logic [63:0] div_q;
    logic [63:0] div_dividend;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign scan_end = (scan_idx_reg == slot_t'(MAX_GROUPS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind == KIND_FINISH)
                    begin
                        state_next = (used_reg == '0) ? S_FIN_OUT : S_FIN_SCAN;
                    end
                    else if (date_ok && (hit || has_free))
                    begin
                        state_next = S_ROW_MUL;
                    end
                end
            end
            S_ROW_MUL:    state_next = S_ROW_WR;
            S_ROW_WR:     state_next = S_IDLE;
            S_FIN_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_FIN_RD;
                end
            end
            S_FIN_RD:     state_next = S_FIN_DAT;
            S_FIN_DAT:    state_next = S_FIN_DSTART;
            S_FIN_DSTART: state_next = S_FIN_DWAIT;
            S_FIN_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = (div_sel_reg == DIV_DISC) ? S_FIN_OUT : S_FIN_DSTART;
                end
            end
            S_FIN_OUT:
            begin
                if (out_free)
                begin
                    state_next = (empty_reg || (used_reg == '0)) ? S_IDLE : S_FIN_SCAN;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = slot_reg;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE:       in_ready = 1'b1;
            S_ROW_MUL:    ram_re = 1'b1;
            S_ROW_WR:     ram_we = 1'b1;
            S_FIN_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = best_slot_reg;
            end
            S_FIN_DSTART: div_start = 1'b1;
            S_FIN_OUT:    out_load = out_free;
            default:
            begin
            end
        endcase
    end

    // saturating accumulate
    function automatic logic [63:0] sat64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

    acc_t base;
    always_comb
    begin
        base = is_new_reg ? '0 : ram_rdata;
        ram_wdata.qty       = sat48(base.qty, {32'd0, qty_reg});
        ram_wdata.price     = sat64(base.price, {40'd0, extended_price_hold});
        ram_wdata.net_price = sat64(base.net_price, {33'd0, dprice_reg});
        ram_wdata.charge    = sat64(base.charge, {25'd0, charge_reg});
        ram_wdata.disc      = sat48(base.disc, {41'd0, disc_reg});
        ram_wdata.cnt       = (base.cnt == '1) ? base.cnt : base.cnt + 32'd1;
    end

    always_comb
    begin
        unique case (div_sel_reg)
            DIV_QTY:   div_dividend = ({16'd0, acc_reg.qty} << 6) + ({16'd0, acc_reg.qty} << 5)
                                    + ({16'd0, acc_reg.qty} << 2);
            DIV_PRICE: div_dividend = acc_reg.price;
            DIV_DISC:  div_dividend = ({16'd0, acc_reg.disc} << 6)
                                    + ({16'd0, acc_reg.disc} << 5)
                                    + ({16'd0, acc_reg.disc} << 2);
            default:   div_dividend = '0;
        endcase
    end

    fgba_acc_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fgba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (acc_reg.cnt),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cutoff_reg    <= CUTOFF_RESET;
            used_reg      <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                cutoff_reg <= cfg_data;
            end
            if (in_fire && (kind == KIND_ROW) && date_ok && !hit)
            begin
                if (has_free)
                begin
                    used_reg[free_slot] <= 1'b1;
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end
            if (state_reg == S_FIN_RD)
            begin
                used_reg[best_slot_reg] <= 1'b0;
            end
            if (out_load && (state_next == S_IDLE))
            begin
                dropped_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fin_drop_reg        <= dropped_reg;
            empty_reg           <= (used_reg == '0);
            scan_idx_reg        <= '0;
            have_reg            <= 1'b0;
            slot_reg            <= hit ? hit_slot : free_slot;
            is_new_reg          <= !hit;
            dprice_reg          <= {7'd0, extended_price} * {24'd0, 7'd100 - disc_clip};
            qty_reg             <= quantity;
            disc_reg            <= disc_clip;
            tax_reg             <= tax;
            extended_price_hold <= extended_price;
            if ((kind == KIND_ROW) && date_ok && !hit && has_free)
            begin
                keys_reg[free_slot] <= in_key;
            end
        end
        if (state_reg == S_ROW_MUL)
        begin
            charge_reg <= {8'd0, dprice_reg} * {31'd0, {1'b0, tax_reg} + 8'd100};
        end
        if (state_reg == S_FIN_SCAN)
        begin
            scan_idx_reg <= scan_idx_reg + slot_t'(1);
            if (used_reg[scan_idx_reg]
                && (!have_reg || (keys_reg[scan_idx_reg] < best_key_reg)))
            begin
                have_reg      <= 1'b1;
                best_slot_reg <= scan_idx_reg;
                best_key_reg  <= keys_reg[scan_idx_reg];
            end
        end
        if (state_reg == S_FIN_DAT)
        begin
            acc_reg     <= ram_rdata;
            div_sel_reg <= DIV_QTY;
        end
        if ((state_reg == S_FIN_DWAIT) && div_done)
        begin
            unique case (div_sel_reg)
                DIV_QTY:
                begin
                    avgq_reg    <= (div_q > 64'h7FFFFF) ? '1 : div_q[22:0];
                    div_sel_reg <= DIV_PRICE;
                end
                DIV_PRICE:
                begin
                    avgp_reg    <= (div_q > 64'hFFFFFF) ? '1 : div_q[23:0];
                    div_sel_reg <= DIV_DISC;
                end
                DIV_DISC:  avgd_reg <= (div_q > 64'h3FFF) ? '1 : div_q[13:0];
                default:
                begin
                end
            endcase
        end
        if (out_load)
        begin
            scan_idx_reg <= '0;
            have_reg     <= 1'b0;
            if (empty_reg)
            begin
                status_reg  <= ST_EMPTY;
                gflag_reg   <= '0;
                gstat_reg   <= '0;
                sqty_reg    <= '0;
                sprice_reg  <= '0;
                sdprice_reg <= '0;
                scharge_reg <= '0;
                oavgq_reg   <= '0;
                oavgp_reg   <= '0;
                oavgd_reg   <= '0;
                ocnt_reg    <= '0;
                last_reg    <= 1'b1;
            end
            else
            begin
                status_reg  <= fin_drop_reg ? ST_DROPPED : ST_GROUP;
                gflag_reg   <= best_key_reg[15:8];
                gstat_reg   <= best_key_reg[7:0];
                sqty_reg    <= acc_reg.qty;
                sprice_reg  <= acc_reg.price;
                sdprice_reg <= acc_reg.net_price;
                scharge_reg <= acc_reg.charge;
                oavgq_reg   <= avgq_reg;
                oavgp_reg   <= avgp_reg;
                oavgd_reg   <= avgd_reg;
                ocnt_reg    <= acc_reg.cnt;
                last_reg    <= (used_reg == '0);
            end
        end
    end

    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign group_flag      = gflag_reg;
    assign group_status    = gstat_reg;
    assign sum_qty         = sqty_reg;
    assign price_total     = sprice_reg;
    assign net_price_total = sdprice_reg;
    assign charge_total    = scharge_reg;
    assign avg_qty         = oavgq_reg;
    assign price_mean      = oavgp_reg;
    assign disc_mean       = oavgd_reg;
    assign row_count       = ocnt_reg;
    assign last            = last_reg;

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> last)
        else $error("empty result without last");

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_load) && (state_reg == S_IDLE) |-> (used_reg == '0))
        else $error("table not empty after finish");

    a_no_ram_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re && !div_busy)
        else $error("RAM write overlaps other work");

endmodule

// ===== hdl/fgba_acc_ram.sv =====
module fgba_acc_ram (
    input  logic           clk,
    input  logic           we,
    input  fgba_pkg::slot_t waddr,
    input  fgba_pkg::acc_t wdata,
    input  logic           re,
    input  fgba_pkg::slot_t raddr,
    output fgba_pkg::acc_t rdata
);
    import fgba_pkg::*;

    acc_t mem [MAX_GROUPS];
    acc_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/fgba_div.sv =====
module fgba_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient
);
    import fgba_pkg::*;

    logic [32:0] rem_reg;
    logic [63:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] rem_shift;
    logic [33:0] diff;

    assign rem_shift = {rem_reg[31:0], quo_reg[63]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                rem_reg <= diff[32:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
